// ----- hdl/sspq_pkg.sv -----
package sspq_pkg;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DEQUEUED = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] item_data;
        logic        [15:0] item_priority;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_data;
        logic        [1:0]  status;
        logic        [4:0]  fill_level;
    } t_out;

    typedef struct packed {
        logic signed [31:0] data;
        logic        [15:0] prio;
    } t_slot;

    typedef struct packed {
        logic  enq;
        logic  deq;
        t_slot item;
    } t_cell_ctl;

endpackage

// ----- hdl/sspq_cell.sv -----
module sspq_cell
    import sspq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,
    input  t_slot     i_left,
    input  logic      i_left_ins,
    input  t_slot     i_right,
    output t_slot     o_slot,
    output logic      o_ins
);

    t_slot r_slot;

    // new item lands ahead of this slot: slot is free or holds strictly lower priority
    assign o_ins  = !i_occ || (i_ctl.item.prio > r_slot.prio);
    assign o_slot = r_slot;

    always_ff @(posedge i_clk) begin
        if (i_ctl.enq) begin
            if (o_ins) begin
                r_slot <= i_left_ins ? i_left : i_ctl.item;
            end
        end else if (i_ctl.deq) begin
            r_slot <= i_right;
        end
    end

endmodule

// ----- hdl/stable_sorted_priority_queue.sv -----
// channel | direction | handshake                   | payload
// in      | input     | i_in_valid / o_in_ready     | i_in  (t_in)
// out     | output    | o_out_valid / i_out_ready   | o_out (t_out)
//
// One item per cycle if not stalled: cells compare and shift in parallel in the transfer cycle.
// The result sits in an output register; a new item is taken while it is being taken.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
// A stalled output holds its result and blocks input until it is taken.
module stable_sorted_priority_queue
    import sspq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out          r_out;
    t_out          n_out;
    logic          w_xfer;
    logic          w_full;
    logic          w_empty;
    t_cell_ctl     w_ctl;
    t_slot         w_slot [DEPTH];
    logic          w_ins  [DEPTH];
    logic [31:0]   w_fill;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_xfer      = i_in_valid && o_in_ready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_ctl.enq  = w_xfer && (i_in.cmd == CMD_ENQUEUE) && !w_full;
    assign w_ctl.deq  = w_xfer && (i_in.cmd == CMD_DEQUEUE) && !w_empty;
    assign w_ctl.item = '{data: i_in.item_data, prio: i_in.item_priority};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_left_ins;

        if (g == 0) begin : g_head
            assign w_left     = '0;
            assign w_left_ins = 1'b0;
        end else begin : g_mid
            assign w_left     = w_slot[g-1];
            assign w_left_ins = w_ins[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_slot[g+1];
        end

        sspq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occ      (CW'(g) < r_count),
            .i_left     (w_left),
            .i_left_ins (w_left_ins),
            .i_right    (w_right),
            .o_slot     (w_slot[g]),
            .o_ins      (w_ins[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.enq) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.deq) begin
            n_count = r_count - CW'(1);
        end
        w_fill = 32'(n_count);

        n_out.out_data   = '0;
        n_out.fill_level = w_fill[4:0];
        if (i_in.cmd == CMD_ENQUEUE) begin
            n_out.status = w_full ? ST_FULL : ST_ENQUEUED;
        end else if (w_empty) begin
            n_out.status = ST_EMPTY;
        end else begin
            n_out.status   = ST_DEQUEUED;
            n_out.out_data = w_slot[0].data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_xfer) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- hdl/sspq_checker.sv -----
module sspq_checker
    import sspq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("no result after input transfer");

    a_full_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_FULL) |->
            (o_out.fill_level == 5'(DEPTH)) && (o_out.out_data == '0))
        else $error("full drop with wrong level or data");

    a_empty_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_EMPTY) |->
            (o_out.fill_level == '0) && (o_out.out_data == '0))
        else $error("empty dequeue with wrong level or data");

    a_enq_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_ENQUEUED) |-> (o_out.out_data == '0))
        else $error("enqueue result carries data");

endmodule

bind stable_sorted_priority_queue sspq_checker #(.DEPTH(DEPTH)) u_sspq_checker (.*);

// ----- tb/sv/tb_stable_sorted_priority_queue.sv -----
module tb_stable_sorted_priority_queue
    import sspq_pkg::*;
();

    class queue_scoreboard;
        int               depth;
        t_slot            ordered_slots[$];
        t_out             due_responses[$];
        int               errors;

        function new(int depth_i);
            depth  = depth_i;
            errors = 0;
        endfunction

        // Predicts the response of one accepted request transfer.
        function void take_request(t_in req);
            t_out  rsp;
            t_slot s;
            int    pos;
            rsp.out_data = '0;
            if (req.cmd == CMD_ENQUEUE) begin
                if (ordered_slots.size() >= depth) begin
                    rsp.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < ordered_slots.size() &&
                           ordered_slots[pos].prio >= req.item_priority) begin
                        pos++;
                    end
                    s.data = req.item_data;
                    s.prio = req.item_priority;
                    ordered_slots.insert(pos, s);
                    rsp.status = ST_ENQUEUED;
                end
            end else begin
                if (ordered_slots.size() == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    s = ordered_slots.pop_front();
                    rsp.out_data = s.data;
                    rsp.status   = ST_DEQUEUED;
                end
            end
            rsp.fill_level = 5'(ordered_slots.size());
            due_responses.push_back(rsp);
        endfunction

        function void check_response(t_out got);
            t_out exp;
            if (due_responses.size() == 0) begin
                $error("unexpected response transfer: out_data %0d status %0d fill_level %0d",
                       got.out_data, got.status, got.fill_level);
                errors++;
                return;
            end
            exp = due_responses.pop_front();
            if (got.out_data !== exp.out_data) begin
                $error("out_data: expected %0d, got %0d", exp.out_data, got.out_data);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.fill_level !== exp.fill_level) begin
                $error("fill_level: expected %0d, got %0d", exp.fill_level, got.fill_level);
                errors++;
            end
        endfunction

        function int pending();
            return due_responses.size();
        endfunction
    endclass

    localparam int QDEPTH      = 16;
    localparam int NUM_ITEMS   = 1850;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in        = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    queue_scoreboard sb = new(QDEPTH);

    bit quiet     = 1'b0;
    bit hold_ask  = 1'b0;
    bit run_done  = 1'b0;
    int cycles    = 0;
    int sent      = 0;

    stable_sorted_priority_queue #(.DEPTH(QDEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.take_request(i_in);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_response(o_out);
            end
        end
    end

    function automatic t_in make_req(logic cmd, logic [31:0] data, logic [15:0] prio);
        t_in r;
        r.cmd           = cmd;
        r.item_data     = data;
        r.item_priority = prio;
        return r;
    endfunction

    function automatic t_in random_req(int enq_pct, bit narrow_prio);
        t_in         r;
        logic [31:0] data;
        logic [15:0] prio;
        case ($urandom_range(0, 9))
            0:       data = 32'h7fff_ffff;
            1:       data = 32'h8000_0000;
            default: data = $urandom;
        endcase
        if (narrow_prio) begin
            case ($urandom_range(0, 5))
                0:       prio = 16'h0000;
                1:       prio = 16'hffff;
                default: prio = 16'($urandom_range(0, 3));
            endcase
        end else begin
            prio = 16'($urandom_range(0, 65535));
        end
        r = make_req(($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE,
                     data, prio);
        return r;
    endfunction

    // Valid stays high after the transfer; the caller changes or drops it.
    task automatic offer(input t_in req);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= req;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain_pause();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // receiver
    initial begin
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = quiet ? 0 : $urandom_range(0, 8);
            if (hold_ask) begin
                hold_ask = 1'b0;
                n = HOLD_CYCLES;
            end
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // sender
    initial begin
        int enq_pct;
        int phase_len;
        int phase;
        bit narrow;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty dequeue, ties, extremes, fill to full, drop on full, partial drain
        offer(make_req(CMD_DEQUEUE, 32'hdead_beef, 16'hffff));
        offer(make_req(CMD_ENQUEUE, 32'h7fff_ffff, 16'h0000));
        offer(make_req(CMD_ENQUEUE, 32'h8000_0000, 16'hffff));
        offer(make_req(CMD_ENQUEUE, 32'h0000_0000, 16'd100));
        offer(make_req(CMD_ENQUEUE, 32'hffff_ffff, 16'd100));
        offer(make_req(CMD_ENQUEUE, 32'h0000_0001, 16'd100));
        offer(make_req(CMD_ENQUEUE, 32'h0000_0002, 16'h0000));
        offer(make_req(CMD_ENQUEUE, 32'h0000_0003, 16'hffff));
        offer(make_req(CMD_ENQUEUE, $urandom, 16'd50));
        offer(make_req(CMD_ENQUEUE, $urandom, 16'd100));
        offer(make_req(CMD_ENQUEUE, $urandom, 16'd7));
        offer(make_req(CMD_ENQUEUE, $urandom, 16'hffff));
        offer(make_req(CMD_ENQUEUE, $urandom, 16'h0000));
        offer(make_req(CMD_ENQUEUE, $urandom, 16'd200));
        offer(make_req(CMD_ENQUEUE, $urandom, 16'd100));
        offer(make_req(CMD_ENQUEUE, $urandom, 16'd1));
        offer(make_req(CMD_ENQUEUE, $urandom, 16'hfffe));
        offer(make_req(CMD_ENQUEUE, 32'h0000_0005, 16'hffff));
        repeat (6) offer(make_req(CMD_DEQUEUE, $urandom, 16'($urandom)));

        phase = 0;
        while (sent < NUM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 80;
                1:       enq_pct = 20;
                default: enq_pct = 50;
            endcase
            narrow    = ($urandom_range(0, 1) == 1);
            quiet     = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 80);
            if (phase == 0 || $urandom_range(0, 9) == 0) begin
                enq_pct  = (phase == 0) ? 80 : enq_pct;
                hold_ask = 1'b1;
            end
            if (phase == 1 || $urandom_range(0, 7) == 0) begin
                drain_pause();
            end
            repeat (phase_len) offer(random_req(enq_pct, narrow));
            phase++;
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
